// ----- rtl/three_way_partition_unit_defines.svh -----
// Assertion macros shared by the three-way partition unit.
`ifndef THREE_WAY_PARTITION_UNIT_DEFINES_SVH
`define THREE_WAY_PARTITION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define TWP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("three_way_partition_unit: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define TWP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("three_way_partition_unit: next-cycle check failed");

`endif

// ----- rtl/twp_pkg.sv -----
// Shared types and constants of the three-way partition unit.
package twp_pkg;

  localparam int unsigned PIVOT_WIDTH = 16;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LOAD      = 4'd1,
    OP_RD_IDX    = 4'd2,
    OP_RD_PTR    = 4'd3,
    OP_WR_IDX    = 4'd4,
    OP_P1_WR_PTR = 4'd5,
    OP_P1_SKIP   = 4'd6,
    OP_P2_INIT   = 4'd7,
    OP_RD_KM1    = 4'd8,
    OP_WR_KM1    = 4'd9,
    OP_P2_WR_PTR = 4'd10,
    OP_P2_SKIP   = 4'd11,
    OP_EM_INIT   = 4'd12,
    OP_EM_CAP    = 4'd13,
    OP_EM_NEXT   = 4'd14,
    OP_CLEAR     = 4'd15
  } dp_op_e;

  typedef struct packed {
    logic less;
    logic greater;
    logic idx_end;
    logic idx_zero;
    logic load_last;
    logic out_taken;
    logic out_last;
  } dp_status_t;

endpackage

// ----- rtl/twp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module twp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/twp_ctrl.sv -----
// Sequencing state machine for loading, both partition passes and the emit pass.
module twp_ctrl import twp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output dp_op_e     op_o,
  output logic       in_stall_o
);

  typedef enum logic [11:0] {
    ST_LOAD    = 12'b0000_0000_0001,
    ST_P1_RD   = 12'b0000_0000_0010,
    ST_P1_CHK  = 12'b0000_0000_0100,
    ST_P1_SWA  = 12'b0000_0000_1000,
    ST_P1_SWB  = 12'b0000_0001_0000,
    ST_P2_RD   = 12'b0000_0010_0000,
    ST_P2_CHK  = 12'b0000_0100_0000,
    ST_P2_SWA  = 12'b0000_1000_0000,
    ST_P2_SWB  = 12'b0001_0000_0000,
    ST_EM_RD   = 12'b0010_0000_0000,
    ST_EM_CAP  = 12'b0100_0000_0000,
    ST_EM_HOLD = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      ST_LOAD: begin
        op_o = OP_LOAD;
        if (status_i.load_last) begin
          state_d = ST_P1_RD;
        end
      end
      ST_P1_RD: begin
        if (status_i.idx_end) begin
          op_o    = OP_P2_INIT;
          state_d = ST_P2_RD;
        end else begin
          op_o    = OP_RD_IDX;
          state_d = ST_P1_CHK;
        end
      end
      ST_P1_CHK: begin
        if (status_i.less) begin
          op_o    = OP_RD_PTR;
          state_d = ST_P1_SWA;
        end else begin
          op_o    = OP_P1_SKIP;
          state_d = ST_P1_RD;
        end
      end
      ST_P1_SWA: begin
        op_o    = OP_WR_IDX;
        state_d = ST_P1_SWB;
      end
      ST_P1_SWB: begin
        op_o    = OP_P1_WR_PTR;
        state_d = ST_P1_RD;
      end
      ST_P2_RD: begin
        if (status_i.idx_zero) begin
          op_o    = OP_EM_INIT;
          state_d = ST_EM_RD;
        end else begin
          op_o    = OP_RD_KM1;
          state_d = ST_P2_CHK;
        end
      end
      ST_P2_CHK: begin
        if (status_i.greater) begin
          op_o    = OP_RD_PTR;
          state_d = ST_P2_SWA;
        end else if (status_i.less) begin
          op_o    = OP_EM_INIT;
          state_d = ST_EM_RD;
        end else begin
          op_o    = OP_P2_SKIP;
          state_d = ST_P2_RD;
        end
      end
      ST_P2_SWA: begin
        op_o    = OP_WR_KM1;
        state_d = ST_P2_SWB;
      end
      ST_P2_SWB: begin
        op_o    = OP_P2_WR_PTR;
        state_d = ST_P2_RD;
      end
      ST_EM_RD: begin
        op_o    = OP_RD_IDX;
        state_d = ST_EM_CAP;
      end
      ST_EM_CAP: begin
        op_o    = OP_EM_CAP;
        state_d = ST_EM_HOLD;
      end
      ST_EM_HOLD: begin
        if (status_i.out_taken) begin
          if (status_i.out_last) begin
            op_o    = OP_CLEAR;
            state_d = ST_LOAD;
          end else begin
            op_o    = OP_EM_NEXT;
            state_d = ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/twp_datapath.sv -----
// Element store, scan pointers, pivot register and output register.
module twp_datapath import twp_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned VALUE_WIDTH  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_op_e                 op_i,
  output dp_status_t             status_o,
  input  logic                   in_valid_i,
  input  logic [VALUE_WIDTH-1:0] element_value_i,
  input  logic                   last_element_i,
  input  logic                   cfg_valid_i,
  input  logic [PIVOT_WIDTH-1:0] pivot_value_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [VALUE_WIDTH-1:0] sorted_value_o,
  output logic                   last_result_o,
  output logic                   overflow_flag_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ELEMENTS);

  logic [CW-1:0]          count_q, count_d;
  logic                   dropped_q, dropped_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [PIVOT_WIDTH-1:0] pivot_q, pivot_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] a_q, a_d;
  logic [VALUE_WIDTH-1:0] sorted_q, sorted_d;
  logic                   last_q, last_d;
  logic                   ovf_q, ovf_d;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [VALUE_WIDTH+PIVOT_WIDTH-1:0] pivot_ext;
  logic signed [VALUE_WIDTH-1:0]      pivot_s;
  logic                               in_acc, has_room;
  logic [CW-1:0]                      idx_m1, count_m1;

  assign pivot_ext = {{VALUE_WIDTH{1'b0}}, pivot_q};
  assign pivot_s   = $signed(pivot_ext[VALUE_WIDTH-1:0]);
  assign in_acc    = (op_i == OP_LOAD) && in_valid_i;
  assign has_room  = (count_q < MaxCount);
  assign idx_m1    = idx_q - CW'(1);
  assign count_m1  = count_q - CW'(1);

  twp_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    case (op_i)
      OP_LOAD: begin
        ram_we    = in_acc && has_room;
        ram_waddr = count_q[AW-1:0];
        ram_wdata = element_value_i;
      end
      OP_RD_IDX: begin
        ram_re = 1'b1;
      end
      OP_RD_PTR: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
      end
      OP_WR_IDX: begin
        ram_we = 1'b1;
      end
      OP_P1_WR_PTR, OP_P2_WR_PTR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = a_q;
      end
      OP_RD_KM1: begin
        ram_re    = 1'b1;
        ram_raddr = idx_m1[AW-1:0];
      end
      OP_WR_KM1: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    a_d         = a_q;
    out_valid_d = out_valid_q && out_stall_i;
    sorted_d    = sorted_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    pivot_d     = cfg_valid_i ? pivot_value_i : pivot_q;
    case (op_i)
      OP_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = count_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_element_i) begin
            idx_d = '0;
            ptr_d = '0;
          end
        end
      end
      OP_RD_PTR: begin
        a_d = ram_rdata;
      end
      OP_P1_WR_PTR: begin
        ptr_d = ptr_q + AW'(1);
        idx_d = idx_q + CW'(1);
      end
      OP_P1_SKIP: begin
        idx_d = idx_q + CW'(1);
      end
      OP_P2_INIT: begin
        idx_d = count_q;
        ptr_d = count_m1[AW-1:0];
      end
      OP_P2_WR_PTR: begin
        if (ptr_q != '0) begin
          ptr_d = ptr_q - AW'(1);
        end
        idx_d = idx_m1;
      end
      OP_P2_SKIP: begin
        idx_d = idx_m1;
      end
      OP_EM_INIT: begin
        idx_d = '0;
      end
      OP_EM_CAP: begin
        out_valid_d = 1'b1;
        sorted_d    = ram_rdata;
        last_d      = (idx_q == count_m1);
        ovf_d       = dropped_q;
      end
      OP_EM_NEXT: begin
        idx_d = idx_q + CW'(1);
      end
      OP_CLEAR: begin
        count_d   = '0;
        dropped_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      idx_q       <= '0;
      ptr_q       <= '0;
      pivot_q     <= PIVOT_WIDTH'(1);
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      idx_q       <= idx_d;
      ptr_q       <= ptr_d;
      pivot_q     <= pivot_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    sorted_q <= sorted_d;
    ovf_q    <= ovf_d;
  end

  assign status_o.less      = $signed(ram_rdata) < pivot_s;
  assign status_o.greater   = $signed(ram_rdata) > pivot_s;
  assign status_o.idx_end   = (idx_q == count_q);
  assign status_o.idx_zero  = (idx_q == '0);
  assign status_o.load_last = in_acc && last_element_i;
  assign status_o.out_taken = out_valid_q && !out_stall_i;
  assign status_o.out_last  = last_q;

  assign out_valid_o     = out_valid_q;
  assign sorted_value_o  = sorted_q;
  assign last_result_o   = last_q;
  assign overflow_flag_o = ovf_q;

endmodule

// ----- rtl/three_way_partition_unit.sv -----
// Top level of the three-way partition unit.
//
// Elements arrive on the input channel (element_value_i, last_element_i) under
// in_valid_i and in_stall_o. One element is taken per cycle while the block loads.
// A transaction with last_element_i set closes the block and starts partitioning
// around the pivot; in_stall_o stays high until the whole block has been emitted.
// Elements beyond MAX_ELEMENTS are dropped and flag every result of that block.
// Pass one reads and compares each element and swaps every element below the pivot
// to the front. Pass two walks from the back, swaps every element above the pivot
// to the back and stops at the first element below it or at the front. The emit
// pass reads each result from the element store into the output register and reads
// the next only once it is taken; a stalled result stays on the outputs until taken.
// The pivot is written on its own channel (cfg_valid_i, cfg_ready_o), always ready;
// it must be written only while the block is idle, which the block does not enforce.
// Reset empties the block, clears the record of dropped elements and sets the pivot
// to one; it does not clear the overflow flag register.
`include "three_way_partition_unit_defines.svh"

module three_way_partition_unit import twp_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned VALUE_WIDTH  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] element_value_i,
  input  logic                   last_element_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_WIDTH-1:0] sorted_value_o,
  output logic                   last_result_o,
  output logic                   overflow_flag_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [PIVOT_WIDTH-1:0] pivot_value_i
);

  dp_op_e     op;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  twp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .status_i  (status),
    .op_o      (op),
    .in_stall_o(in_stall_o)
  );

  twp_datapath #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .status_o       (status),
    .in_valid_i     (in_valid_i),
    .element_value_i(element_value_i),
    .last_element_i (last_element_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .pivot_value_i  (pivot_value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .sorted_value_o (sorted_value_o),
    .last_result_o  (last_result_o),
    .overflow_flag_o(overflow_flag_o)
  );

  `TWP_ASSERT_IMP(a_no_load_while_emitting, out_valid_o, in_stall_o)
  `TWP_ASSERT_NXT(a_busy_after_last, in_valid_i && !in_stall_o && last_element_i, in_stall_o)
  `TWP_ASSERT_NXT(a_idle_after_final, out_valid_o && !out_stall_i && last_result_o, !out_valid_o)

endmodule
